// File: hdl/poql_pkg.sv
`default_nettype none

package poql_pkg;

	// Default sizes of the lock manager.
	localparam int NUM_LEVELS_DEF = 64;
	localparam int NUM_CPUS_DEF   = 64;

	// Fixed widths of the request and result fields.
	localparam int ID_W     = 6;
	localparam int STATUS_W = 2;

	// The highest-priority search works on groups of this many levels.
	localparam int GROUP_SIZE = 8;
	localparam int GIDX_W     = 3;

	// Request kinds.
	localparam logic MODE_ACQUIRE = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_DUP       = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_NOT_OWNER = 2'd2;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SEARCH,
		S_PICK,
		S_GRANT
	} state_t;

endpackage

`default_nettype wire

// File: hdl/priority_ordered_queue_lock.sv
`default_nettype none

// Lock manager with one owner and a FIFO wait queue for each priority level.
// Level 0 is the highest priority.
//
// A request is transferred at a rising edge with start high and busy low. It
// carries mode (0 acquire, 1 release), cpu_id and prio_level. Each request
// gives one result, shown for exactly one cycle with done high: status,
// grant_valid, grant_cpu and grant_level. The receiver cannot stall, so a
// result must be taken in its cycle.
//
// Sequencing: an acquire gives its result from EXEC, and busy is low again
// while done is high; no new request is taken before the last result shows.
// A release runs through EXEC, SEARCH and PICK when nobody waits, and through
// GRANT as well when the lock passes on: the search over the queue flags and
// the read of the chosen queue head need these states. Head, tail and link
// memories each have one write port and one registered read port.
//
// Reset clears the owner, the queue flags and the enrolled flags at once. The
// head, tail and link memories are not cleared. They are read only after being
// written.

module priority_ordered_queue_lock
	import poql_pkg::*;
#(
	parameter int NUM_LEVELS = NUM_LEVELS_DEF,
	parameter int NUM_CPUS   = NUM_CPUS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire logic                mode,
	input  wire logic [ID_W-1:0]     cpu_id,
	input  wire logic [ID_W-1:0]     prio_level,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic                     grant_valid,
	output logic [ID_W-1:0]          grant_cpu,
	output logic [ID_W-1:0]          grant_level
);

	localparam int LVL_W      = $clog2(NUM_LEVELS);
	localparam int CPU_W      = $clog2(NUM_CPUS);
	localparam int NUM_GROUPS = (NUM_LEVELS + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
	localparam int PAD_W      = NUM_GROUPS * GROUP_SIZE;

	// Sequencer and control state.
	state_t                  state_q, state_d;
	logic [NUM_LEVELS-1:0]   nonempty_q;
	logic [NUM_CPUS-1:0]     enrolled_q;
	logic                    owner_busy_q;
	logic [CPU_W-1:0]        owner_cpu_q;
	logic [LVL_W-1:0]        owner_level_q;

	// Registered result.
	logic                    done_q;
	logic [STATUS_W-1:0]     status_q;
	logic                    grant_valid_q;
	logic [ID_W-1:0]         grant_cpu_q;
	logic [ID_W-1:0]         grant_level_q;

	// The request being worked on.
	logic                    req_mode_q;
	logic                    req_cpu_ok_q;
	logic [CPU_W-1:0]        req_cpu_q;
	logic [LVL_W-1:0]        req_lvl_q;

	// Queue memories and their read registers.
	logic [CPU_W-1:0]        head_mem [NUM_LEVELS];
	logic [CPU_W-1:0]        tail_mem [NUM_LEVELS];
	logic [CPU_W-1:0]        link_mem [NUM_CPUS];
	logic [CPU_W-1:0]        head_rd_q;
	logic [CPU_W-1:0]        tail_rd_q;
	logic [CPU_W-1:0]        link_rd_q;

	// Grouped search results.
	logic [NUM_GROUPS-1:0]   grp_any_q;
	logic [GIDX_W-1:0]       grp_idx_q [NUM_GROUPS];
	logic [LVL_W-1:0]        found_q;

	logic                    accept;
	logic [LVL_W-1:0]        lvl_in;
	logic                    cpu_in_ok;
	logic [LVL_W-1:0]        tail_ra;
	logic                    is_dup;
	logic                    is_owner;
	logic [PAD_W-1:0]        ne_pad;
	logic                    any_found;
	logic [GRP_W-1:0]        sel_grp;
	logic [GIDX_W-1:0]       sel_idx;
	logic [LVL_W-1:0]        found_lvl;

	// Memory write controls, decoded from the sequencer state.
	logic                    head_we;
	logic [CPU_W-1:0]        head_wd;
	logic                    tail_we;
	logic                    link_we;

	assign accept    = start && (state_q == S_IDLE);
	assign busy      = (state_q != S_IDLE);

	// A level beyond the configured range falls into the lowest-priority level.
	assign lvl_in    = (32'(prio_level) >= NUM_LEVELS) ? LVL_W'(NUM_LEVELS - 1)
		: LVL_W'(prio_level);
	assign cpu_in_ok = (32'(cpu_id) < NUM_CPUS);

	// A release reads the tail of the owner's level; an acquire reads the tail
	// of its own level so that it can link behind it.
	assign tail_ra   = (mode == MODE_RELEASE) ? owner_level_q : lvl_in;

	// An out-of-range processor counts as a duplicate, and can never be the
	// owner. The range flag guards against aliasing after truncation.
	assign is_dup    = !req_cpu_ok_q || enrolled_q[req_cpu_q];
	assign is_owner  = owner_busy_q && req_cpu_ok_q && (req_cpu_q == owner_cpu_q);

	assign ne_pad    = PAD_W'(nonempty_q);

	// Second level of the search: the first group with a waiting processor.
	always_comb begin
		any_found = 1'b0;
		sel_grp   = '0;
		sel_idx   = '0;
		for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
			if (grp_any_q[g]) begin
				any_found = 1'b1;
				sel_grp   = GRP_W'(g);
				sel_idx   = grp_idx_q[g];
			end
		end
		found_lvl = LVL_W'({sel_grp, sel_idx});
	end

	// Next state and memory write decode.
	always_comb begin
		state_d = state_q;
		head_we = 1'b0;
		head_wd = req_cpu_q;
		tail_we = 1'b0;
		link_we = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				if (req_mode_q == MODE_ACQUIRE) begin
					if (!is_dup) begin
						// Join the tail of the level, or open it as its head.
						tail_we = 1'b1;
						if (nonempty_q[req_lvl_q]) begin
							link_we = 1'b1;
						end else begin
							head_we = 1'b1;
						end
					end
				end else if (is_owner) begin
					// The owner leaves the head of its level. Its successor
					// becomes the head unless the owner was also the tail.
					state_d = S_SEARCH;
					if (tail_rd_q != owner_cpu_q) begin
						head_we = 1'b1;
						head_wd = link_rd_q;
					end
				end
			end
			S_SEARCH: begin
				state_d = S_PICK;
			end
			S_PICK: begin
				state_d = any_found ? S_GRANT : S_IDLE;
			end
			S_GRANT: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Lock state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nonempty_q    <= '0;
			enrolled_q    <= '0;
			owner_busy_q  <= 1'b0;
			owner_cpu_q   <= '0;
			owner_level_q <= '0;
			done_q        <= 1'b0;
			status_q      <= STAT_OK;
			grant_valid_q <= 1'b0;
			grant_cpu_q   <= '0;
			grant_level_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_EXEC: begin
					if (req_mode_q == MODE_ACQUIRE) begin
						done_q        <= 1'b1;
						grant_valid_q <= 1'b0;
						grant_cpu_q   <= '0;
						grant_level_q <= '0;
						if (is_dup) begin
							status_q <= STAT_DUP;
						end else begin
							status_q               <= STAT_OK;
							enrolled_q[req_cpu_q]  <= 1'b1;
							nonempty_q[req_lvl_q]  <= 1'b1;
							// A free lock means every queue is empty, so the
							// new arrival is the one to take it.
							if (!owner_busy_q) begin
								owner_busy_q  <= 1'b1;
								owner_cpu_q   <= req_cpu_q;
								owner_level_q <= req_lvl_q;
								grant_valid_q <= 1'b1;
								grant_cpu_q   <= ID_W'(req_cpu_q);
								grant_level_q <= ID_W'(req_lvl_q);
							end
						end
					end else if (!is_owner) begin
						done_q        <= 1'b1;
						status_q      <= STAT_NOT_OWNER;
						grant_valid_q <= 1'b0;
						grant_cpu_q   <= '0;
						grant_level_q <= '0;
					end else begin
						if (tail_rd_q == owner_cpu_q) begin
							nonempty_q[owner_level_q] <= 1'b0;
						end
						enrolled_q[owner_cpu_q] <= 1'b0;
						owner_busy_q            <= 1'b0;
					end
				end
				S_PICK: begin
					if (!any_found) begin
						done_q        <= 1'b1;
						status_q      <= STAT_OK;
						grant_valid_q <= 1'b0;
						grant_cpu_q   <= '0;
						grant_level_q <= '0;
					end
				end
				S_GRANT: begin
					owner_busy_q  <= 1'b1;
					owner_cpu_q   <= head_rd_q;
					owner_level_q <= found_q;
					done_q        <= 1'b1;
					status_q      <= STAT_OK;
					grant_valid_q <= 1'b1;
					grant_cpu_q   <= ID_W'(head_rd_q);
					grant_level_q <= ID_W'(found_q);
				end
				default: begin
				end
			endcase
		end
	end

	// Request capture and the first level of the search. The search looks at
	// the queue flags as the release left them in the EXEC state.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_mode_q   <= mode;
			req_cpu_ok_q <= cpu_in_ok;
			req_cpu_q    <= CPU_W'(cpu_id);
			req_lvl_q    <= lvl_in;
		end
		if (state_q == S_SEARCH) begin
			for (int g = 0; g < NUM_GROUPS; g++) begin
				grp_any_q[g] <= |ne_pad[g*GROUP_SIZE +: GROUP_SIZE];
				grp_idx_q[g] <= '0;
				for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
					if (ne_pad[g*GROUP_SIZE + b]) begin
						grp_idx_q[g] <= GIDX_W'(b);
					end
				end
			end
		end
		if (state_q == S_PICK) begin
			found_q <= found_lvl;
		end
	end

	// Queue memories: one write and one registered read each. A release
	// rewrites the head of the owner's level, an acquire that of its own.
	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[(req_mode_q == MODE_RELEASE) ? owner_level_q : req_lvl_q] <= head_wd;
		end
		head_rd_q <= head_mem[found_lvl];
	end

	always_ff @(posedge clk) begin
		if (tail_we) begin
			tail_mem[req_lvl_q] <= req_cpu_q;
		end
		tail_rd_q <= tail_mem[tail_ra];
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[tail_rd_q] <= req_cpu_q;
		end
		link_rd_q <= link_mem[owner_cpu_q];
	end

	assign done        = done_q;
	assign status      = status_q;
	assign grant_valid = grant_valid_q;
	assign grant_cpu   = grant_cpu_q;
	assign grant_level = grant_level_q;

	// The owner always heads a non-empty level and is enrolled.
	a_owner_queued: assert property (@(posedge clk) disable iff (!arst_n)
		owner_busy_q |-> (nonempty_q[owner_level_q] && enrolled_q[owner_cpu_q]))
		else $error("owner is not at the head of a non-empty level");

	// Outside a release in progress, a free lock leaves nobody waiting.
	a_free_no_waiters: assert property (@(posedge clk) disable iff (!arst_n)
		(!owner_busy_q && (state_q == S_IDLE)) |-> (nonempty_q == '0))
		else $error("lock is free while processors wait");

	// No result appears in the cycle right after a transfer.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result appeared too early");

	// A grant reports the owner that the lock state now holds.
	a_grant_matches_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(done && grant_valid) |-> (owner_busy_q && (grant_cpu == ID_W'(owner_cpu_q))
			&& (grant_level == ID_W'(owner_level_q))))
		else $error("grant does not match the owner");

	// An ignored request never grants.
	a_ignored_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STAT_OK)) |-> !grant_valid)
		else $error("ignored request granted the lock");

endmodule

`default_nettype wire

// File: tb/poql_lock_monitor.sv
`default_nettype none

// Watches the request and result channels of the lock manager. It keeps its own
// copy of the queues and the owner, works out the outcome of every transfer, and
// compares each result with the oldest outcome still due.
module poql_lock_monitor
	import poql_pkg::*;
#(
	parameter int NUM_LEVELS = NUM_LEVELS_DEF,
	parameter int NUM_CPUS   = NUM_CPUS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                busy,
	input  wire logic                mode,
	input  wire logic [ID_W-1:0]     cpu_id,
	input  wire logic [ID_W-1:0]     prio_level,
	input  wire logic                done,
	input  wire logic [STATUS_W-1:0] status,
	input  wire logic                grant_valid,
	input  wire logic [ID_W-1:0]     grant_cpu,
	input  wire logic [ID_W-1:0]     grant_level,
	output int                       fail_count,
	output int                       pending
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                granted;
		logic [ID_W-1:0]     cpu;
		logic [ID_W-1:0]     level;
	} lock_outcome_t;

	lock_outcome_t outcomes_due[$];
	lock_outcome_t oldest;

	// Shadow of the lock state.
	logic [NUM_LEVELS-1:0] queue_occupied;
	logic [ID_W-1:0]       queue_first [NUM_LEVELS];
	logic [ID_W-1:0]       queue_last  [NUM_LEVELS];
	logic [ID_W-1:0]       successor   [NUM_CPUS];
	logic [NUM_CPUS-1:0]   waiting_or_owner;
	logic                  lock_held;
	logic [ID_W-1:0]       holder_cpu;
	logic [ID_W-1:0]       holder_level;

	initial fail_count = 0;

	assign pending = outcomes_due.size();

	task automatic report_mismatch(input string what);
		$display("%0t: lock result mismatch: %s", $time, what);
		fail_count++;
	endtask

	// Hands the lock to the head of the lowest-numbered occupied level, if any.
	function automatic logic hand_over();
		for (int lv = 0; lv < NUM_LEVELS; lv++) begin
			if (queue_occupied[lv]) begin
				lock_held    = 1'b1;
				holder_cpu   = queue_first[lv];
				holder_level = lv[ID_W-1:0];
				return 1'b1;
			end
		end
		lock_held = 1'b0;
		return 1'b0;
	endfunction

	function automatic lock_outcome_t apply_request(input logic req_mode,
			input logic [ID_W-1:0] cpu, input logic [ID_W-1:0] req_level);
		lock_outcome_t r;
		int            lvl;
		int            ol;
		logic [ID_W-1:0] h;
		r   = '0;
		lvl = req_level;
		if (lvl >= NUM_LEVELS)
			lvl = NUM_LEVELS - 1;
		if (req_mode == MODE_ACQUIRE) begin
			if (cpu >= NUM_CPUS || waiting_or_owner[cpu]) begin
				r.status = STAT_DUP;
			end else begin
				r.status = STAT_OK;
				waiting_or_owner[cpu] = 1'b1;
				if (queue_occupied[lvl]) begin
					if (queue_last[lvl] < NUM_CPUS)
						successor[queue_last[lvl]] = cpu;
				end else begin
					queue_occupied[lvl] = 1'b1;
					queue_first[lvl]    = cpu;
				end
				queue_last[lvl] = cpu;
				if (!lock_held)
					r.granted = hand_over();
			end
		end else begin
			if (!lock_held || cpu != holder_cpu || cpu >= NUM_CPUS) begin
				r.status = STAT_NOT_OWNER;
			end else begin
				r.status = STAT_OK;
				ol = holder_level;
				if (ol < NUM_LEVELS && queue_occupied[ol]) begin
					h = queue_first[ol];
					if (h == queue_last[ol] || h >= NUM_CPUS)
						queue_occupied[ol] = 1'b0;
					else
						queue_first[ol] = successor[h];
				end
				waiting_or_owner[cpu] = 1'b0;
				lock_held = 1'b0;
				r.granted = hand_over();
			end
		end
		if (r.granted) begin
			r.cpu   = holder_cpu;
			r.level = holder_level;
		end
		return r;
	endfunction

	// A result leaves before a transfer in the same edge can add its outcome, so
	// the compare runs first.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outcomes_due.delete();
			queue_occupied   = '0;
			waiting_or_owner = '0;
			lock_held        = 1'b0;
			holder_cpu       = '0;
			holder_level     = '0;
		end else begin
			if (done) begin
				if (outcomes_due.size() == 0) begin
					report_mismatch("result with no request outstanding");
				end else begin
					oldest = outcomes_due.pop_front();
					if (status !== oldest.status)
						report_mismatch($sformatf("status %0d, want %0d",
							status, oldest.status));
					if (grant_valid !== oldest.granted)
						report_mismatch($sformatf("grant_valid %0b, want %0b",
							grant_valid, oldest.granted));
					if (grant_cpu !== oldest.cpu)
						report_mismatch($sformatf("grant_cpu %0d, want %0d",
							grant_cpu, oldest.cpu));
					if (grant_level !== oldest.level)
						report_mismatch($sformatf("grant_level %0d, want %0d",
							grant_level, oldest.level));
				end
			end
			if (start && !busy)
				outcomes_due.push_back(apply_request(mode, cpu_id, prio_level));
		end
	end

endmodule

`default_nettype wire

// File: tb/tb_priority_ordered_queue_lock.sv
`default_nettype none

// Top of the lock manager bench. It resets the block, plays a short directed
// sequence that walks through grants, queueing, hand-over across levels and the
// rejected cases, then random lock traffic. Checking lives in the monitor; this
// module only makes stimulus and gives the verdict.
module tb_priority_ordered_queue_lock;
	import poql_pkg::*;

	localparam int CYCLE_LIMIT     = 400000;
	localparam int ITEM_COUNT      = 1900;
	localparam int PHASE_LENGTH    = 400;
	localparam int DRAIN_LIMIT     = 500;
	localparam int SETTLE_CYCLES   = 10;

	logic            clk = 1'b0;
	logic            arst_n = 1'b1;
	logic            start = 1'b0;
	logic            mode = MODE_ACQUIRE;
	logic [ID_W-1:0] cpu_id = '0;
	logic [ID_W-1:0] prio_level = '0;

	wire logic                busy;
	wire logic                done;
	wire logic [STATUS_W-1:0] status;
	wire logic                grant_valid;
	wire logic [ID_W-1:0]     grant_cpu;
	wire logic [ID_W-1:0]     grant_level;

	int fail_count;
	int pending;
	int cycles = 0;
	int requests_sent = 0;

	// Last processor seen to receive the lock. Releases mostly come from it, so
	// that most random traffic actually moves the lock along the queues.
	logic [ID_W-1:0] last_granted = '0;

	// Percent chance per cycle that the sender holds off. The receiver cannot
	// stall, so the phases that would stall it run with the sender busy instead.
	int idle_pct_by_phase[4] = '{0, 48, 0, 27};

	always #10 clk = ~clk;

	priority_ordered_queue_lock dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.cpu_id      (cpu_id),
		.prio_level  (prio_level),
		.done        (done),
		.status      (status),
		.grant_valid (grant_valid),
		.grant_cpu   (grant_cpu),
		.grant_level (grant_level)
	);

	poql_lock_monitor lock_monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.mode        (mode),
		.cpu_id      (cpu_id),
		.prio_level  (prio_level),
		.done        (done),
		.status      (status),
		.grant_valid (grant_valid),
		.grant_cpu   (grant_cpu),
		.grant_level (grant_level),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// Guard against a hang anywhere in the run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Follows the results only to steer the stimulus; nothing is checked here.
	always @(posedge clk) begin
		if (done && grant_valid)
			last_granted <= grant_cpu;
	end

	// Presents one request and returns at the edge that transfers it. The caller
	// is always at a rising edge, so the next request or an idle cycle can be set
	// up at once without touching start twice in the same step.
	task automatic issue(input logic m, input logic [ID_W-1:0] c,
			input logic [ID_W-1:0] l);
		start      <= 1'b1;
		mode       <= m;
		cpu_id     <= c;
		prio_level <= l;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests_sent++;
	endtask

	// Holds start low for a random number of cycles.
	task automatic sender_gap(input int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	initial begin
		logic [ID_W-1:0] c;
		logic [ID_W-1:0] l;
		int              pct;
		int              waited;

		// The falling edge of the reset line starts the asynchronous reset.
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A free lock is granted at once, and a second acquire by
		// the owner is a duplicate. A release by someone else is refused.
		issue(MODE_ACQUIRE, 6'd0, 6'd0);
		issue(MODE_ACQUIRE, 6'd0, 6'd5);
		issue(MODE_RELEASE, 6'd1, 6'd0);
		// Waiters on the lowest and the highest level, and a duplicate from a
		// waiter. A release by a waiter is not a release by the owner.
		issue(MODE_ACQUIRE, 6'd63, 6'd63);
		issue(MODE_ACQUIRE, 6'd5, 6'd63);
		issue(MODE_ACQUIRE, 6'd10, 6'd0);
		issue(MODE_ACQUIRE, 6'd63, 6'd0);
		issue(MODE_RELEASE, 6'd63, 6'd63);
		// Hand-over within level 0 first, then down to level 63.
		issue(MODE_RELEASE, 6'd0, 6'd0);
		issue(MODE_RELEASE, 6'd10, 6'd0);
		// A newcomer on a higher level jumps ahead of the level 63 waiter.
		issue(MODE_ACQUIRE, 6'd42, 6'd42);
		issue(MODE_RELEASE, 6'd63, 6'd0);
		issue(MODE_RELEASE, 6'd42, 6'd0);
		// The last holder leaves with nobody waiting, then a release of a free lock.
		issue(MODE_RELEASE, 6'd5, 6'd63);
		issue(MODE_RELEASE, 6'd5, 6'd63);
		// Alternating bit patterns on the id and level fields.
		issue(MODE_ACQUIRE, 6'd21, 6'd42);
		issue(MODE_ACQUIRE, 6'd42, 6'd21);
		issue(MODE_RELEASE, 6'd21, 6'd42);
		issue(MODE_RELEASE, 6'd42, 6'd21);

		// Random part. Acquires crowd a few levels so that queues grow deep, and
		// most releases come from the last known owner. The rest are releases by
		// random processors, which the block refuses unless one is the owner.
		while (requests_sent < ITEM_COUNT) begin
			pct = idle_pct_by_phase[(requests_sent / PHASE_LENGTH) % 4];
			sender_gap(pct);
			if ($urandom_range(99) < 45) begin
				if ($urandom_range(9) < 8)
					c = last_granted;
				else
					c = ID_W'($urandom_range(63));
				l = ID_W'($urandom_range(63));
				issue(MODE_RELEASE, c, l);
			end else begin
				c = ID_W'($urandom_range(63));
				case ($urandom_range(3))
					0: l = ID_W'($urandom_range(3));
					1: l = ID_W'(60 + $urandom_range(3));
					default: l = ID_W'($urandom_range(63));
				endcase
				issue(MODE_ACQUIRE, c, l);
			end
		end
		start <= 1'b0;

		// Let the last results come out, then wait out SETTLE_CYCLES so that the block
		// can show any stray result.
		waited = 0;
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

// File: priority_ordered_queue_lock.f
hdl/poql_pkg.sv
hdl/priority_ordered_queue_lock.sv
tb/poql_lock_monitor.sv
tb/tb_priority_ordered_queue_lock.sv
